// ----- hdl/modbus_ascii_request_framer_defines.svh -----
// Assertion macros shared by the framer checker.
`ifndef MODBUS_ASCII_REQUEST_FRAMER_DEFINES_SVH
`define MODBUS_ASCII_REQUEST_FRAMER_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define MBAF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("framer check failed");

// Next-cycle implication, checked while out of reset.
`define MBAF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("framer check failed");

`endif

// ----- hdl/mbaf_pkg.sv -----
// Shared types, codes and character helpers of the Modbus ASCII framer.
`timescale 1ns / 1ps
`default_nettype none
package mbaf_pkg;

	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_DATA  = 2'd2;

	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] FUNC_WRITE_MULTI = 8'h10;

	// index of the last binary byte of each job type
	localparam logic [2:0] LAST_BYTE_READ  = 3'd5;
	localparam logic [2:0] LAST_BYTE_WRITE = 3'd6;
	localparam logic [2:0] LAST_BYTE_DATA  = 3'd1;

	// one queued job: a header or a data word, plus whether it closes the frame
	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  func;
		logic [15:0] word;
		logic [6:0]  cnt;
		logic        close;
	} job_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] res;
		if (nib <= 4'd9)
			res = 8'h30 + {4'h0, nib};
		else
			res = 8'h37 + {4'h0, nib};
		return res;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/mbaf_front.sv -----
// Front end: accepts items, tracks the open write frame and issues jobs.
`timescale 1ns / 1ps
`default_nettype none
module mbaf_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              full,
	input  wire logic [1:0]        kind,
	input  wire logic [2:0]        read_function,
	input  wire logic [15:0]       start_address,
	input  wire logic [6:0]        register_count,
	input  wire logic [15:0]       data_word,
	output logic                   push,
	output mbaf_pkg::job_t         job
);
	import mbaf_pkg::*;

	logic       write_open_q;
	logic [6:0] words_left_q;
	logic       write_open_d;
	logic [6:0] words_left_d;
	logic       accept;

	assign accept = in_valid && !full;

	always_comb begin
		push         = 1'b0;
		job.kind     = kind;
		job.func     = read_function;
		job.word     = (kind == KIND_DATA) ? data_word : start_address;
		job.cnt      = register_count;
		job.close    = 1'b0;
		write_open_d = write_open_q;
		words_left_d = words_left_q;
		if (accept) begin
			case (kind)
				KIND_READ: begin
					push         = 1'b1;
					job.close    = 1'b1;
					write_open_d = 1'b0;
					words_left_d = '0;
				end
				KIND_WRITE: begin
					push         = 1'b1;
					job.close    = (register_count == 7'd0);
					write_open_d = (register_count != 7'd0);
					words_left_d = register_count;
				end
				KIND_DATA: begin
					// words with no open write are dropped here
					if (write_open_q && words_left_q != 7'd0) begin
						push         = 1'b1;
						words_left_d = words_left_q - 7'd1;
						job.close    = (words_left_q == 7'd1);
						if (words_left_q == 7'd1)
							write_open_d = 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_open_q <= 1'b0;
			words_left_q <= '0;
		end else begin
			write_open_q <= write_open_d;
			words_left_q <= words_left_d;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/mbaf_queue.sv -----
// Small job queue between the front end and the character sequencer.
`timescale 1ns / 1ps
`default_nettype none
module mbaf_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire mbaf_pkg::job_t    push_job,
	input  wire logic              pop,
	output logic                   full,
	output logic                   head_valid,
	output mbaf_pkg::job_t         head_job
);
	import mbaf_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(DEPTH - 1))
			r = '0;
		else
			r = p + PTR_W'(1);
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hdl/mbaf_back.sv -----
// Back end: turns jobs into hex characters, keeps the LRC, drives the output register.
`timescale 1ns / 1ps
`default_nettype none
module mbaf_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [7:0]        slave_address,
	input  wire logic              head_valid,
	input  wire mbaf_pkg::job_t    head_job,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [7:0]             frame_char,
	output logic                   last_char,
	output logic                   frame_end
);
	import mbaf_pkg::*;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_COLON = 2'd1;
	localparam logic [1:0] PH_BYTES = 2'd2;
	localparam logic [1:0] PH_CLOSE = 2'd3;

	localparam logic [1:0] CC_LRC_HI = 2'd0;
	localparam logic [1:0] CC_LRC_LO = 2'd1;
	localparam logic [1:0] CC_CR     = 2'd2;
	localparam logic [1:0] CC_LF     = 2'd3;

	job_t       job_q;
	logic [1:0] phase_q;
	logic [2:0] byte_idx_q;
	logic       nib_q;
	logic [1:0] cc_q;
	logic [7:0] lrc_q;
	logic       out_valid_q;
	logic [7:0] char_q;
	logic       last_q;
	logic       end_q;

	logic       out_free;
	logic       adv;
	logic [2:0] last_byte;
	logic [7:0] cur_byte;
	logic [7:0] lrc_val;
	logic [7:0] cur_char;
	logic       job_last;
	logic       cur_end;
	logic [7:0] lrc_next;
	logic       new_hdr;

	assign out_free = !out_valid_q || !out_stall;
	assign adv      = (phase_q != PH_IDLE) && out_free;
	assign lrc_val  = 8'h00 - lrc_q;

	always_comb begin
		case (job_q.kind)
			KIND_READ:  last_byte = LAST_BYTE_READ;
			KIND_WRITE: last_byte = LAST_BYTE_WRITE;
			default:    last_byte = LAST_BYTE_DATA;
		endcase
	end

	// binary byte at the current index of the job
	always_comb begin
		cur_byte = 8'h00;
		if (job_q.kind == KIND_DATA) begin
			cur_byte = (byte_idx_q == 3'd0) ? job_q.word[15:8] : job_q.word[7:0];
		end else begin
			case (byte_idx_q)
				3'd0:    cur_byte = slave_address;
				3'd1:    cur_byte = (job_q.kind == KIND_WRITE) ? FUNC_WRITE_MULTI
				                                              : {5'd0, job_q.func};
				3'd2:    cur_byte = job_q.word[15:8];
				3'd3:    cur_byte = job_q.word[7:0];
				3'd4:    cur_byte = 8'h00;
				3'd5:    cur_byte = {1'b0, job_q.cnt};
				3'd6:    cur_byte = {job_q.cnt, 1'b0};
				default: cur_byte = 8'h00;
			endcase
		end
	end

	always_comb begin
		cur_char = CHAR_COLON;
		cur_end  = 1'b0;
		case (phase_q)
			PH_BYTES: cur_char = nib_q ? hex_char(cur_byte[3:0]) : hex_char(cur_byte[7:4]);
			PH_CLOSE: begin
				case (cc_q)
					CC_LRC_HI: cur_char = hex_char(lrc_val[7:4]);
					CC_LRC_LO: cur_char = hex_char(lrc_val[3:0]);
					CC_CR:     cur_char = CHAR_CR;
					default: begin
						cur_char = CHAR_LF;
						cur_end  = 1'b1;
					end
				endcase
			end
			default: cur_char = CHAR_COLON;
		endcase
	end

	assign job_last = ((phase_q == PH_BYTES) && nib_q && (byte_idx_q == last_byte)
	                   && !job_q.close)
	               || ((phase_q == PH_CLOSE) && (cc_q == CC_LF));

	assign pop      = head_valid && ((phase_q == PH_IDLE) || (adv && job_last));
	assign new_hdr  = head_job.kind != KIND_DATA;
	assign lrc_next = (adv && phase_q == PH_BYTES && nib_q) ? lrc_q + cur_byte : lrc_q;

	always_ff @(posedge clk) begin
		if (pop)
			job_q <= head_job;
		if (adv) begin
			char_q <= cur_char;
			last_q <= job_last;
			end_q  <= cur_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			byte_idx_q  <= '0;
			nib_q       <= 1'b0;
			cc_q        <= CC_LRC_HI;
			lrc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free)
				out_valid_q <= adv;
			lrc_q <= (pop && new_hdr) ? 8'h00 : lrc_next;
			if (pop) begin
				phase_q    <= new_hdr ? PH_COLON : PH_BYTES;
				byte_idx_q <= '0;
				nib_q      <= 1'b0;
				cc_q       <= CC_LRC_HI;
			end else if (adv) begin
				case (phase_q)
					PH_COLON: phase_q <= PH_BYTES;
					PH_BYTES: begin
						nib_q <= !nib_q;
						if (nib_q) begin
							if (byte_idx_q == last_byte) begin
								byte_idx_q <= '0;
								phase_q    <= job_q.close ? PH_CLOSE : PH_IDLE;
							end else begin
								byte_idx_q <= byte_idx_q + 3'd1;
							end
						end
					end
					PH_CLOSE: begin
						cc_q <= cc_q + 2'd1;
						if (cc_q == CC_LF)
							phase_q <= PH_IDLE;
					end
					default: ;
				endcase
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_char = char_q;
	assign last_char  = last_q;
	assign frame_end  = end_q;

endmodule
`default_nettype wire

// ----- hdl/modbus_ascii_request_framer.sv -----
// Modbus ASCII request framer top level: front end, job queue, character sequencer.
// Path: the first character of an item passes the queue entry, the sequencer state and
// the output register. Throughput: one character per cycle there while out_stall is low
// and jobs wait; a data item gives 4 characters (8 when it closes), a header 15 to 19.
// The job queue decouples input transfers from the character rate set by the sequencer.
// Reset (arst_n low) closes any open frame, empties the queue and sets slave 32.
`timescale 1ns / 1ps
`default_nettype none
module modbus_ascii_request_framer #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration: slave address register
	input  wire logic        cfg_wr_en,
	input  wire logic [7:0]  cfg_wr_data,
	// input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [2:0]  read_function,
	input  wire logic [15:0] start_address,
	input  wire logic [6:0]  register_count,
	input  wire logic [15:0] data_word,
	// output channel, one character per transfer
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       frame_char,
	output logic             last_char,
	output logic             frame_end
);
	import mbaf_pkg::*;

	logic [7:0] slave_address_q;
	logic       q_full;
	logic       q_push;
	job_t       q_push_job;
	logic       q_pop;
	logic       q_head_valid;
	job_t       q_head_job;

	// station address; write it only while the block is idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			slave_address_q <= 8'd32;
		else if (cfg_wr_en)
			slave_address_q <= cfg_wr_data;
	end

	// input stalls only when the job queue is full
	assign in_stall = q_full;

	// front end: tracks the open write frame, drops orphan data words
	mbaf_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.full           (q_full),
		.kind           (kind),
		.read_function  (read_function),
		.start_address  (start_address),
		.register_count (register_count),
		.data_word      (data_word),
		.push           (q_push),
		.job            (q_push_job)
	);

	mbaf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_job   (q_push_job),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (q_head_valid),
		.head_job   (q_head_job)
	);

	// back end: hex encoding, running LRC, CR LF, output register
	mbaf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.slave_address (slave_address_q),
		.head_valid    (q_head_valid),
		.head_job      (q_head_job),
		.pop           (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.frame_char    (frame_char),
		.last_char     (last_char),
		.frame_end     (frame_end)
	);

endmodule
`default_nettype wire

// ----- hdl/mbaf_checker.sv -----
// Port-level checker for the framer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "modbus_ascii_request_framer_defines.svh"
module mbaf_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] frame_char,
	input wire logic       last_char,
	input wire logic       frame_end
);
	import mbaf_pkg::*;

	`MBAF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`MBAF_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(frame_char))
	`MBAF_ASSERT_NOW(a_end_is_last, clk, arst_n, out_valid && frame_end, last_char)
	`MBAF_ASSERT_NOW(a_end_is_lf, clk, arst_n, out_valid && frame_end, frame_char == CHAR_LF)

endmodule

bind modbus_ascii_request_framer mbaf_checker u_mbaf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.frame_char (frame_char),
	.last_char  (last_char),
	.frame_end  (frame_end)
);
`default_nettype wire

// ----- tb/modbus_ascii_request_framer_checker.sv -----
// Checker for the Modbus ASCII framer: predicts the character stream and compares each transfer.
`timescale 1ns / 1ps
module modbus_ascii_request_framer_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [7:0]  cfg_wr_data,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [2:0]  read_function,
	input  wire logic [15:0] start_address,
	input  wire logic [6:0]  register_count,
	input  wire logic [15:0] data_word,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [7:0]  frame_char,
	input  wire logic        last_char,
	input  wire logic        frame_end,
	output int               fail_count,
	output int               expected_count,
	output int               chars_checked
);
	import mbaf_pkg::*;

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [7:0] ch;
		logic       last_flag;
		logic       end_flag;
	} frame_char_t;

	frame_char_t frame_q[$];     // characters still owed by the framer
	frame_char_t item_chars[$];  // characters of the item being predicted

	logic [7:0] slave_addr;
	logic [7:0] lrc_acc;
	logic [6:0] words_pending;
	logic       write_frame_open;
	int         mismatch_total;
	int         checked_total;

	function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
		if (nib < 4'd10)
			return 8'h30 + {4'h0, nib};
		return 8'h41 + {4'h0, nib} - 8'h0A;
	endfunction

	task automatic emit_char(input logic [7:0] c, input logic closing_lf);
		frame_char_t e;
		e.ch = c;
		e.last_flag = 1'b0;
		e.end_flag = closing_lf;
		item_chars.push_back(e);
	endtask

	task automatic emit_byte(input logic [7:0] b);
		emit_char(ascii_hex(b[7:4]), 1'b0);
		emit_char(ascii_hex(b[3:0]), 1'b0);
		lrc_acc = lrc_acc + b;
	endtask

	task automatic emit_word(input logic [15:0] w);
		emit_byte(w[15:8]);
		emit_byte(w[7:0]);
	endtask

	// LRC, CR, LF; closes whatever frame was open
	task automatic emit_close();
		logic [7:0] lrc;
		lrc = 8'h00 - lrc_acc;
		emit_byte_chars_only(lrc);
		emit_char(CHAR_CR, 1'b0);
		emit_char(CHAR_LF, 1'b1);
		write_frame_open = 1'b0;
		words_pending = '0;
	endtask

	// LRC digits are not part of the sum
	task automatic emit_byte_chars_only(input logic [7:0] b);
		emit_char(ascii_hex(b[7:4]), 1'b0);
		emit_char(ascii_hex(b[3:0]), 1'b0);
	endtask

	task automatic frame_item(input logic [1:0] k, input logic [2:0] f, input logic [15:0] a,
			input logic [6:0] c, input logic [15:0] d);
		frame_char_t e;
		item_chars.delete();
		case (k)
			KIND_READ: begin
				write_frame_open = 1'b0;
				words_pending = '0;
				lrc_acc = '0;
				emit_char(CHAR_COLON, 1'b0);
				emit_byte(slave_addr);
				emit_byte({5'd0, f});
				emit_word(a);
				emit_word({9'd0, c});
				emit_close();
			end
			KIND_WRITE: begin
				// a header always restarts; an open frame is dropped silently
				write_frame_open = 1'b0;
				words_pending = '0;
				lrc_acc = '0;
				emit_char(CHAR_COLON, 1'b0);
				emit_byte(slave_addr);
				emit_byte(FUNC_WRITE_MULTI);
				emit_word(a);
				emit_word({9'd0, c});
				emit_byte({c, 1'b0});
				if (c == 7'd0) begin
					emit_close();
				end else begin
					write_frame_open = 1'b1;
					words_pending = c;
				end
			end
			KIND_DATA: begin
				if (write_frame_open && words_pending != 7'd0) begin
					emit_word(d);
					words_pending = words_pending - 7'd1;
					if (words_pending == 7'd0)
						emit_close();
				end
			end
			default: begin
			end
		endcase
		foreach (item_chars[i]) begin
			e = item_chars[i];
			e.last_flag = (i == item_chars.size() - 1);
			frame_q.push_back(e);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_char_t want;
		if (!arst_n) begin
			frame_q.delete();
			slave_addr = 8'd32;
			lrc_acc = '0;
			words_pending = '0;
			write_frame_open = 1'b0;
			mismatch_total = 0;
			checked_total = 0;
			fail_count <= 0;
			expected_count <= 0;
			chars_checked <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				checked_total++;
				if (frame_q.size() == 0) begin
					mismatch_total++;
					if (mismatch_total <= REPORT_LIMIT)
						$display("%0t: unexpected character %h last %b end %b", $realtime,
							frame_char, last_char, frame_end);
				end else begin
					want = frame_q.pop_front();
					if (frame_char !== want.ch || last_char !== want.last_flag ||
							frame_end !== want.end_flag) begin
						mismatch_total++;
						if (mismatch_total <= REPORT_LIMIT)
							$display("%0t: mismatch expected %h last %b end %b, got %h last %b end %b",
								$realtime, want.ch, want.last_flag, want.end_flag,
								frame_char, last_char, frame_end);
					end
				end
			end
			if (in_valid && !in_stall)
				frame_item(kind, read_function, start_address, register_count, data_word);
			if (cfg_wr_en)
				slave_addr = cfg_wr_data;
			fail_count <= mismatch_total;
			expected_count <= frame_q.size();
			chars_checked <= checked_total;
		end
	end

endmodule

// ----- tb/modbus_ascii_request_framer_tb.sv -----
// Testbench top for the Modbus ASCII request framer: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module modbus_ascii_request_framer_tb;
	import mbaf_pkg::*;

	// kind code the block must ignore
	localparam logic [1:0] KIND_RESERVED = 2'd3;
	localparam int HOLD_OFF_CYCLES = 80;
	// extra wait after the last owed character; an ignored item never enters the job queue
	localparam int SETTLE_CYCLES = 10;
	localparam int PHASE_ITEMS = 34;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [7:0]  cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  kind;
	logic [2:0]  read_function;
	logic [15:0] start_address;
	logic [6:0]  register_count;
	logic [15:0] data_word;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  frame_char;
	logic        last_char;
	logic        frame_end;

	int fail_count;
	int expected_count;
	int chars_checked;

	// sender and receiver idling switches, and the request for one long receiver hold-off
	logic sender_idles;
	logic receiver_idles;
	logic hold_off_req;

	int items_sent;
	int ignored_sent;
	int slave_writes;
	int hold_offs;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	modbus_ascii_request_framer DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.read_function  (read_function),
		.start_address  (start_address),
		.register_count (register_count),
		.data_word      (data_word),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.frame_char     (frame_char),
		.last_char      (last_char),
		.frame_end      (frame_end)
	);

	modbus_ascii_request_framer_checker frame_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.read_function  (read_function),
		.start_address  (start_address),
		.register_count (register_count),
		.data_word      (data_word),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.frame_char     (frame_char),
		.last_char      (last_char),
		.frame_end      (frame_end),
		.fail_count     (fail_count),
		.expected_count (expected_count),
		.chars_checked  (chars_checked)
	);

	// Receiver: random stalls, or one long hold-off when asked. The hold-off is
	// counted here so the sender keeps offering items and the queue backs up.
	initial begin
		out_stall = 1'b0;
		hold_offs = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_stall <= 1'b1;
				hold_off_req <= 1'b0;
				hold_offs++;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				out_stall <= receiver_idles && ($urandom_range(99) < 12);
			end
		end
	end

	// Offer one item and hold it until the transfer. Valid stays high afterwards
	// unless an idle gap follows, so back-to-back items never toggle it in one step.
	task automatic send_item(input logic [1:0] k, input logic [2:0] f, input logic [15:0] a,
			input logic [6:0] c, input logic [15:0] d);
		kind <= k;
		read_function <= f;
		start_address <= a;
		register_count <= c;
		data_word <= d;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (sender_idles && $urandom_range(99) < 12) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic send_read(input logic [2:0] f);
		send_item(KIND_READ, f, 16'($urandom), 7'($urandom), 16'($urandom));
		items_sent++;
	endtask

	task automatic send_write(input logic [6:0] c);
		send_item(KIND_WRITE, 3'($urandom), 16'($urandom), c, 16'($urandom));
		items_sent++;
	endtask

	task automatic send_data(input logic [15:0] d, input bit in_frame);
		send_item(KIND_DATA, 3'($urandom), 16'($urandom), 7'($urandom), d);
		if (in_frame)
			items_sent++;
		else
			ignored_sent++;
	endtask

	// sender pause: wait for every owed character, then let an ignored item clear
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_count != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_slave(input logic [7:0] v);
		cfg_wr_data <= v;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		slave_writes++;
	endtask

	// Mostly complete frames with random content; some stray data, reserved kinds,
	// and write frames cut short by a new header.
	task automatic run_random_phase(input int n_items);
		int start_count;
		int r;
		int cnt;
		start_count = items_sent;
		while (items_sent - start_count < n_items) begin
			r = $urandom_range(99);
			if (r < 45) begin
				if ($urandom_range(99) < 8)
					cnt = $urandom_range(7, 20);
				else
					cnt = $urandom_range(1, 6);
				send_write(7'(cnt));
				for (int i = 0; i < cnt; i++) begin
					if ($urandom_range(99) < 5)
						break;
					send_data(16'($urandom), 1'b1);
				end
			end else if (r < 78) begin
				if ($urandom_range(99) < 12)
					send_read(3'($urandom));
				else
					send_read($urandom_range(0, 1) ? 3'd4 : 3'd3);
			end else if (r < 86) begin
				send_data(16'($urandom), 1'b0);
			end else if (r < 92) begin
				send_item(KIND_RESERVED, 3'($urandom), 16'($urandom), 7'($urandom),
					16'($urandom));
				ignored_sent++;
			end else begin
				send_write(7'd0);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 8'h00;
		in_valid = 1'b0;
		kind = KIND_READ;
		read_function = 3'd3;
		start_address = 16'h0000;
		register_count = 7'd0;
		data_word = 16'h0000;
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
		hold_off_req = 1'b0;
		items_sent = 0;
		ignored_sent = 0;
		slave_writes = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, slave address still at its reset value
		send_item(KIND_READ, 3'd3, 16'h0000, 7'd0, 16'($urandom));
		send_item(KIND_READ, 3'd4, 16'hFFFF, 7'd127, 16'($urandom));
		// function codes outside 3 and 4 go out as given
		send_item(KIND_READ, 3'd0, 16'h5A5A, 7'd1, 16'($urandom));
		send_item(KIND_READ, 3'd7, 16'hA5A5, 7'd64, 16'($urandom));
		items_sent += 4;
		// zero-count write closes at once
		send_item(KIND_WRITE, 3'd0, 16'h0000, 7'd0, 16'hFFFF);
		items_sent++;
		// data with nothing open, reserved kind
		send_data(16'hFFFF, 1'b0);
		send_item(KIND_RESERVED, 3'd7, 16'hFFFF, 7'd127, 16'hFFFF);
		ignored_sent++;
		send_write(7'd2);
		send_data(16'h0000, 1'b1);
		send_data(16'hFFFF, 1'b1);
		send_data(16'h1234, 1'b0);
		// full-count write dropped by a read header
		send_item(KIND_WRITE, 3'd7, 16'hFFFF, 7'd127, 16'h0000);
		items_sent++;
		send_data(16'hABCD, 1'b1);
		send_read(3'd3);
		// header during an open write restarts the frame
		send_write(7'd3);
		send_data(16'h7FFE, 1'b1);
		send_write(7'd1);
		send_data(16'h8001, 1'b1);
		// reserved kind inside an open frame leaves it open
		send_write(7'd1);
		send_item(KIND_RESERVED, 3'd0, 16'h0000, 7'd0, 16'h0000);
		ignored_sent++;
		send_data(16'hC3C3, 1'b1);
		wait_drained();

		write_slave(8'h00);
		run_random_phase(PHASE_ITEMS);
		wait_drained();

		// no idling on either side
		write_slave(8'hFF);
		sender_idles <= 1'b0;
		receiver_idles <= 1'b0;
		run_random_phase(PHASE_ITEMS);
		wait_drained();
		sender_idles <= 1'b1;
		receiver_idles <= 1'b1;

		// long receiver hold-off while items keep coming
		write_slave(8'($urandom));
		hold_off_req <= 1'b1;
		run_random_phase(PHASE_ITEMS);
		wait_drained();

		write_slave(8'($urandom));
		run_random_phase(PHASE_ITEMS);
		wait_drained();
		repeat (20) @(posedge clk);

		$display("Run covered %0d framed items, %0d ignored items, %0d characters checked,",
			items_sent, ignored_sent, chars_checked);
		$display("  %0d slave address writes and %0d receiver hold-offs.", slave_writes,
			hold_offs);
		if (fail_count == 0 && expected_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// hang guard
	initial begin
		#3_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/mbaf_pkg.sv
hdl/mbaf_front.sv
hdl/mbaf_queue.sv
hdl/mbaf_back.sv
hdl/modbus_ascii_request_framer.sv
hdl/mbaf_checker.sv
tb/modbus_ascii_request_framer_checker.sv
tb/modbus_ascii_request_framer_tb.sv
